// File: hdl/tpjd_pkg.sv
package tpjd_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int ID_W   = 16;
  localparam int PAGE_W = 16;
  localparam int PRIO_W = 8;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int JOB_W  = ID_W + PAGE_W + PRIO_W;

  localparam logic [PRIO_W-1:0] THRESHOLD_RESET = 8'd5;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PAGE_W-1:0] pages;
    logic [PRIO_W-1:0] prio;
  } job_t;

endpackage

// File: hdl/threshold_priority_job_deque_top.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   req_type, job_id, page_count, priority_req
// out       output     out_valid / out_ready status, taken_id, taken_pages, taken_priority,
//                                             occupancy
// cfg       input      cfg_valid / cfg_ready cfg_data (threshold)
//
// add and unused codes: execute state, then finish state, which fills the output register.
// take: execute, take, then finish state; an empty queue goes from execute to finish.
// cancel: execute, scan state stepping through every stored job, then finish; one stored job per cycle
// through the ring memory (one read and one write port, registered read).
// in_ready is low while a request is in progress; a finished result waits in the output
// register, the next item may be accepted meanwhile and its result waits until that clears.
// rst is synchronous: empty queue, head at slot 0, threshold 5, no clearing pass.
module threshold_priority_job_deque_top
  import tpjd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ID_W-1:0]   job_id,
  input  logic [PAGE_W-1:0] page_count,
  input  logic [PRIO_W-1:0] priority_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [ID_W-1:0]   taken_id,
  output logic [PAGE_W-1:0] taken_pages,
  output logic [PRIO_W-1:0] taken_priority,
  output logic [CNT_W-1:0]  occupancy,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PRIO_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TAKE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(DEPTH - 1);

  logic [2:0]        state;
  logic [IDX_W-1:0]  head_index;
  logic [CNT_W-1:0]  job_count;
  logic [PRIO_W-1:0] threshold;
  logic [CNT_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  wr_pos;
  logic [REQ_W-1:0]  req;
  job_t              req_job;
  logic [STAT_W-1:0] res_status;
  job_t              res_job;

  job_t              mem [DEPTH];
  job_t              rd_data;

  logic              mem_re;
  logic              mem_we;
  logic [IDX_W-1:0]  rd_off;
  logic [IDX_W-1:0]  wr_off;
  logic [IDX_W-1:0]  rd_slot;
  logic [IDX_W-1:0]  wr_slot;
  logic [CNT_W-1:0]  rd_pos_next;
  logic [CNT_W-1:0]  wr_pos_next;
  logic              keep;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign keep        = (rd_data.id != req_job.id);
  assign rd_pos_next = rd_pos + CNT_W'(1);
  assign wr_pos_next = keep ? wr_pos + CNT_W'(1) : wr_pos;
  assign rd_slot     = ring_add(head_index, rd_off);
  assign wr_slot     = ring_add(head_index, wr_off);

  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    rd_off = '0;
    wr_off = '0;
    unique case (state)
      S_EXEC: begin
        if (req == REQ_ADD && job_count != DEPTH_C) begin
          mem_we = 1'b1;
          wr_off = (req_job.prio < threshold) ? job_count[IDX_W-1:0] : DEPTH_M1;
        end
        if ((req == REQ_TAKE || req == REQ_CANCEL) && job_count != '0) begin
          mem_re = 1'b1;
        end
      end
      S_TAKE: begin
        wr_off = IDX_W'(1);
      end
      S_SCAN: begin
        mem_we = keep;
        wr_off = wr_pos[IDX_W-1:0];
        mem_re = (rd_pos_next < job_count);
        rd_off = rd_pos_next[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[rd_slot];
    end
    if (mem_we) begin
      mem[wr_slot] <= (state == S_SCAN) ? rd_data : req_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_index <= '0;
      job_count  <= '0;
      threshold  <= THRESHOLD_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req           <= req_type;
            req_job.id    <= job_id;
            req_job.pages <= page_count;
            req_job.prio  <= priority_req;
            state         <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_job <= '0;
          rd_pos  <= '0;
          wr_pos  <= '0;
          unique case (req)
            REQ_ADD: begin
              state <= S_FIN;
              if (job_count == DEPTH_C) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                job_count  <= job_count + CNT_W'(1);
                if (req_job.prio >= threshold) begin
                  head_index <= wr_slot;
                end
              end
            end
            REQ_TAKE: begin
              if (job_count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= ST_OK;
                state      <= S_TAKE;
              end
            end
            REQ_CANCEL: begin
              if (job_count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_FIN;
            end
          endcase
        end
        S_TAKE: begin
          res_job    <= rd_data;
          head_index <= wr_slot;
          job_count  <= job_count - CNT_W'(1);
          state      <= S_FIN;
        end
        S_SCAN: begin
          rd_pos <= rd_pos_next;
          wr_pos <= wr_pos_next;
          if (rd_pos_next >= job_count) begin
            job_count  <= wr_pos_next;
            res_status <= (wr_pos_next == job_count) ? ST_NOT_FOUND : ST_OK;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            taken_id       <= res_job.id;
            taken_pages    <= res_job.pages;
            taken_priority <= res_job.prio;
            occupancy      <= job_count;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/tb_threshold_priority_job_deque_top.sv
`timescale 1ns / 100ps

module tb_threshold_priority_job_deque_top;
  import tpjd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ID_W-1:0]   id;
    logic [PAGE_W-1:0] pages;
    logic [PRIO_W-1:0] prio;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [ID_W-1:0]   tid;
    logic [PAGE_W-1:0] tpages;
    logic [PRIO_W-1:0] tprio;
    logic [CNT_W-1:0]  occ;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = '0;
  logic [ID_W-1:0]   job_id = '0;
  logic [PAGE_W-1:0] page_count = '0;
  logic [PRIO_W-1:0] priority_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   taken_id;
  logic [PAGE_W-1:0] taken_pages;
  logic [PRIO_W-1:0] taken_priority;
  logic [CNT_W-1:0]  occupancy;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [PRIO_W-1:0] cfg_data = '0;

  request_t pending_reqs[$];
  reply_t   replies_due[$];
  request_t offer;
  logic     in_accepted = 1'b0;
  logic     calm = 1'b0;
  int       send_gap = 0;
  int       rx_gap = 0;
  int       rx_hold = 0;
  int       errors = 0;

  // predictor state
  job_t              ring[DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_count;
  logic [PRIO_W-1:0] thr_model;

  logic [ID_W-1:0] id_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002,
                                  16'h0003, 16'h8000, 16'h5A5A, 16'h00FF};

  threshold_priority_job_deque_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .job_id         (job_id),
    .page_count     (page_count),
    .priority_req   (priority_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .taken_id       (taken_id),
    .taken_pages    (taken_pages),
    .taken_priority (taken_priority),
    .occupancy      (occupancy),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic reply_t deque_apply(request_t r);
    reply_t y;
    job_t   kept[$];
    job_t   j;
    y = '0;
    y.st = ST_OK;
    j.id = r.id;
    j.pages = r.pages;
    j.prio = r.prio;
    case (r.req)
      REQ_ADD: begin
        if (ring_count >= DEPTH) begin
          y.st = ST_FULL;
        end else begin
          if (r.prio < thr_model) begin
            ring[(ring_head + ring_count) % DEPTH] = j;
          end else begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring[ring_head] = j;
          end
          ring_count++;
        end
      end
      REQ_TAKE: begin
        if (ring_count == 0) begin
          y.st = ST_EMPTY;
        end else begin
          j = ring[ring_head];
          y.tid = j.id;
          y.tpages = j.pages;
          y.tprio = j.prio;
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
      end
      REQ_CANCEL: begin
        if (ring_count == 0) begin
          y.st = ST_EMPTY;
        end else begin
          for (int k = 0; k < ring_count; k++) begin
            if (ring[(ring_head + k) % DEPTH].id != r.id) begin
              kept.push_back(ring[(ring_head + k) % DEPTH]);
            end
          end
          if (kept.size() == ring_count) begin
            y.st = ST_NOT_FOUND;
          end
          ring_count = kept.size();
          foreach (kept[k]) begin
            ring[(ring_head + k) % DEPTH] = kept[k];
          end
        end
      end
      default: ;
    endcase
    y.occ = CNT_W'(ring_count);
    return y;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        if (!calm && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          offer = pending_reqs.pop_front();
          req_type <= offer.req;
          job_id <= offer.id;
          page_count <= offer.pages;
          priority_req <= offer.prio;
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    reply_t want;
    request_t got_req;
    if (rst) begin
      ring_head = 0;
      ring_count = 0;
      thr_model = THRESHOLD_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_model = cfg_data;
      end
      if (in_valid && in_ready) begin
        got_req.req = req_type;
        got_req.id = job_id;
        got_req.pages = page_count;
        got_req.prio = priority_req;
        replies_due.push_back(deque_apply(got_req));
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          flag_error("result with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          if (status !== want.st)
            flag_error($sformatf("status got %0d want %0d", status, want.st));
          if (taken_id !== want.tid)
            flag_error($sformatf("taken_id got %h want %h", taken_id, want.tid));
          if (taken_pages !== want.tpages)
            flag_error($sformatf("taken_pages got %h want %h", taken_pages, want.tpages));
          if (taken_priority !== want.tprio)
            flag_error($sformatf("taken_priority got %h want %h", taken_priority, want.tprio));
          if (occupancy !== want.occ)
            flag_error($sformatf("occupancy got %0d want %0d", occupancy, want.occ));
        end
      end
    end
    in_accepted <= !rst && in_valid && in_ready;
  end

  function automatic request_t make_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                        logic [PAGE_W-1:0] pages, logic [PRIO_W-1:0] prio);
    request_t r;
    r.req = req;
    r.id = id;
    r.pages = pages;
    r.prio = prio;
    return r;
  endfunction

  function automatic request_t random_req(logic [PRIO_W-1:0] thr, int add_pct, int take_pct);
    request_t    r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) r.req = REQ_ADD;
    else if (roll < add_pct + take_pct) r.req = REQ_TAKE;
    else if (roll < 97) r.req = REQ_CANCEL;
    else r.req = REQ_UNUSED;
    if ($urandom_range(0, 4) != 0) r.id = id_pool[$urandom_range(0, 7)];
    else r.id = ID_W'($urandom);
    r.pages = PAGE_W'($urandom);
    case ($urandom_range(0, 5))
      0: r.prio = thr;
      1: r.prio = thr - 1'b1;
      default: r.prio = PRIO_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [PRIO_W-1:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [PRIO_W-1:0] thr, int n, int add_pct, int take_pct,
                           int hold_cycles);
    write_threshold(thr);
    @(posedge clk);
    rx_hold = hold_cycles;
    repeat (n) pending_reqs.push_back(random_req(thr, add_pct, take_pct));
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass at reset threshold
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_CANCEL, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_ADD, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0001, 16'h1234, 8'h04));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0002, 16'hA5A5, 8'h05));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0001, 16'h5A5A, 8'hC8));
    pending_reqs.push_back(make_req(REQ_UNUSED, 16'h0001, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_CANCEL, 16'h0007, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_CANCEL, 16'h0001, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_CANCEL, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0003, 16'h0003, 8'h04));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0004, 16'h0004, 8'h06));
    pending_reqs.push_back(make_req(REQ_CANCEL, 16'h0004, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_ADD, 16'h0005, 16'h0005, 8'h00));
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    pending_reqs.push_back(make_req(REQ_TAKE, 16'h0000, 16'h0000, 8'h00));
    wait_drained();

    // long receiver stall while the queue fills
    run_phase(8'd0, 130, 70, 15, 200);
    run_phase(8'd255, 130, 40, 35, 0);
    run_phase(8'd128, 130, 35, 45, 0);
    run_phase(8'd1, 130, 45, 20, 0);
    run_phase(PRIO_W'($urandom), 130, 50, 30, 0);
    @(posedge clk);
    calm = 1'b1;
    run_phase(THRESHOLD_RESET, 130, 50, 30, 0);

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_threshold_priority_job_deque_top: done, clean");
    end else begin
      $display("tb_threshold_priority_job_deque_top: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_threshold_priority_job_deque_top: done, errors");
    $finish;
  end

endmodule
